/* hdl/cadc_pkg.sv */
// ----------------------------------------------------------------------------
// cadc_pkg: shared definitions for the card access door controller
// Table geometry, operation, event and mode codes, register indexes,
// the preset card list and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package cadc_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PRESET_N    = 4;
    localparam int RESET_CNT   = (TABLE_DEPTH < PRESET_N) ? TABLE_DEPTH : PRESET_N;

    localparam int UID_W  = 40;
    localparam int DIST_W = 10;
    localparam int HOLD_W = 16;

    // Operation codes.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SCAN = 2'd1;
    localparam logic [1:0] OP_ADD  = 2'd2;

    // Event codes.
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_GRANTED   = 3'd1;
    localparam logic [2:0] EV_DENY_UNK  = 3'd2;
    localparam logic [2:0] EV_DENY_FULL = 3'd3;
    localparam logic [2:0] EV_ADDED     = 3'd4;
    localparam logic [2:0] EV_DUPLICATE = 3'd5;
    localparam logic [2:0] EV_TBL_FULL  = 3'd6;

    // Door modes.
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_OPEN = 2'd1;
    localparam logic [1:0] MODE_LOCK = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_NEAR_THR  = 2'd0;
    localparam logic [1:0] REG_OPEN_HOLD = 2'd1;
    localparam logic [1:0] REG_DENY_HOLD = 2'd2;
    localparam logic [1:0] REG_CAPACITY  = 2'd3;

    localparam logic [DIST_W-1:0] RST_NEAR_THR  = 10'd5;
    localparam logic [HOLD_W-1:0] RST_OPEN_HOLD = 16'd4500;
    localparam logic [HOLD_W-1:0] RST_DENY_HOLD = 16'd1500;
    localparam logic [1:0]        RST_CAPACITY  = 2'd2;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SEARCH
    } t_state;

    typedef struct packed {
        logic capture;
        logic step;
        logic apply;
    } t_cmd;

    typedef struct packed {
        logic search_done;
        logic out_busy;
    } t_sts;

    function automatic logic [UID_W-1:0] preset_uid(input int idx);
        logic [UID_W-1:0] uid;
        case (idx)
            0:       uid = 40'h56622E0218;
            1:       uid = 40'hF094D85CE0;
            2:       uid = 40'h4027C441E2;
            3:       uid = 40'hA473C44152;
            default: uid = '0;
        endcase
        return uid;
    endfunction

endpackage

/* hdl/cadc_ctrl.sv */
// ----------------------------------------------------------------------------
// cadc_ctrl: sequencing state machine
// Takes one input word at a time, steps the table search in the datapath
// and commits the result once the output register is free.
// ----------------------------------------------------------------------------
module cadc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  cadc_pkg::t_sts  i_sts,
    output cadc_pkg::t_cmd  o_cmd
);

    cadc_pkg::t_state r_state;
    cadc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cadc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cadc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = cadc_pkg::S_SEARCH;
                end
            end
            cadc_pkg::S_SEARCH: begin
                if (i_sts.search_done && !i_sts.out_busy) begin
                    n_state = cadc_pkg::S_IDLE;
                end
            end
            default: n_state = cadc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            cadc_pkg::S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            cadc_pkg::S_SEARCH: begin
                o_cmd.step  = !i_sts.search_done;
                o_cmd.apply = i_sts.search_done && !i_sts.out_busy;
            end
            default: begin
                o_cmd      = '0;
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* hdl/cadc_dp.sv */
// ----------------------------------------------------------------------------
// cadc_dp: datapath of the door controller
// Configuration registers, captured word, allow list with its search
// pointer, door mode and hold timer, and the output register.
// ----------------------------------------------------------------------------
module cadc_dp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic [1:0]  i_op,
    input  logic [39:0] i_card_uid,
    input  logic [9:0]  i_slot_a_distance,
    input  logic [9:0]  i_slot_b_distance,
    input  cadc_pkg::t_cmd i_cmd,
    output cadc_pkg::t_sts o_sts,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_code,
    output logic [1:0]  o_door_mode,
    output logic        o_door_open,
    output logic        o_slot_a_busy,
    output logic        o_slot_b_busy,
    output logic [1:0]  o_occupied_count,
    output logic [4:0]  o_stored_cards
);

    localparam logic [cadc_pkg::CNT_W-1:0] DEPTH_CNT =
        cadc_pkg::CNT_W'(cadc_pkg::TABLE_DEPTH);
    localparam logic [cadc_pkg::CNT_W-1:0] RESET_CNT =
        cadc_pkg::CNT_W'(cadc_pkg::RESET_CNT);

    // Configuration.
    logic [cadc_pkg::DIST_W-1:0] r_near_thr;
    logic [cadc_pkg::HOLD_W-1:0] r_open_hold;
    logic [cadc_pkg::HOLD_W-1:0] r_deny_hold;
    logic [1:0]                  r_capacity;

    // Captured word.
    logic [1:0]                 r_op;
    logic [cadc_pkg::UID_W-1:0] r_uid;
    logic                       r_a_busy;
    logic                       r_b_busy;

    // Allow list and search.
    logic [cadc_pkg::UID_W-1:0] r_table [cadc_pkg::TABLE_DEPTH];
    logic [cadc_pkg::CNT_W-1:0] r_count;
    logic [cadc_pkg::CNT_W-1:0] r_pos;
    logic                       r_found;

    // Door state.
    logic [1:0]                  r_mode;
    logic [cadc_pkg::HOLD_W-1:0] r_hold;

    // Output register.
    logic       r_out_valid;
    logic [2:0] r_res_event;
    logic       r_res_a;
    logic       r_res_b;

    logic [1:0]                  occupied;
    logic                        lot_full;
    logic                        need_search;
    logic                        hit;
    logic [2:0]                  n_event;
    logic [1:0]                  n_mode;
    logic [cadc_pkg::HOLD_W-1:0] n_hold;
    logic                        do_append;
    logic [cadc_pkg::HOLD_W-1:0] hold_inc;
    logic [cadc_pkg::CNT_W+4:0]  count_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_thr  <= cadc_pkg::RST_NEAR_THR;
            r_open_hold <= cadc_pkg::RST_OPEN_HOLD;
            r_deny_hold <= cadc_pkg::RST_DENY_HOLD;
            r_capacity  <= cadc_pkg::RST_CAPACITY;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                cadc_pkg::REG_NEAR_THR:  r_near_thr  <= i_cfg_wdata[cadc_pkg::DIST_W-1:0];
                cadc_pkg::REG_OPEN_HOLD: r_open_hold <= i_cfg_wdata;
                cadc_pkg::REG_DENY_HOLD: r_deny_hold <= i_cfg_wdata;
                cadc_pkg::REG_CAPACITY:  r_capacity  <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Occupancy is resolved when the word is captured.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_uid    <= i_card_uid;
            r_a_busy <= (i_slot_a_distance != '0) && (i_slot_a_distance <= r_near_thr);
            r_b_busy <= (i_slot_b_distance != '0) && (i_slot_b_distance <= r_near_thr);
        end
    end

    assign occupied = {1'b0, r_a_busy} + {1'b0, r_b_busy};
    assign lot_full = (occupied >= r_capacity);

    // Only a scan that could be granted and an add that has room walk the list.
    assign need_search = (r_count != '0) &&
        (((r_op == cadc_pkg::OP_SCAN) && (r_mode == cadc_pkg::MODE_IDLE) && !lot_full) ||
         ((r_op == cadc_pkg::OP_ADD) && (r_count < DEPTH_CNT)));

    assign hit = (r_table[r_pos[cadc_pkg::IDX_W-1:0]] == r_uid);

    assign o_sts.search_done = r_found || (r_pos >= r_count) || !need_search;
    assign o_sts.out_busy    = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pos   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.step) begin
            r_found <= hit;
            r_pos   <= r_pos + 1'b1;
        end
    end

    assign hold_inc = (r_hold != '1) ? r_hold + 1'b1 : r_hold;

    always_comb begin
        n_event   = cadc_pkg::EV_NONE;
        n_mode    = r_mode;
        n_hold    = r_hold;
        do_append = 1'b0;
        case (r_op)
            cadc_pkg::OP_TICK: begin
                if (r_mode != cadc_pkg::MODE_IDLE) begin
                    n_hold = hold_inc;
                    if (hold_inc >= ((r_mode == cadc_pkg::MODE_OPEN) ? r_open_hold
                                                                      : r_deny_hold)) begin
                        n_mode = cadc_pkg::MODE_IDLE;
                    end
                end
            end
            cadc_pkg::OP_SCAN: begin
                if (r_mode == cadc_pkg::MODE_IDLE) begin
                    n_hold = '0;
                    if (lot_full) begin
                        n_event = cadc_pkg::EV_DENY_FULL;
                        n_mode  = cadc_pkg::MODE_LOCK;
                    end else if (r_found) begin
                        n_event = cadc_pkg::EV_GRANTED;
                        n_mode  = cadc_pkg::MODE_OPEN;
                    end else begin
                        n_event = cadc_pkg::EV_DENY_UNK;
                        n_mode  = cadc_pkg::MODE_LOCK;
                    end
                    // A zero hold ends the hold within the same word.
                    if (((n_mode == cadc_pkg::MODE_OPEN) ? r_open_hold : r_deny_hold) == '0) begin
                        n_mode = cadc_pkg::MODE_IDLE;
                    end
                end
            end
            cadc_pkg::OP_ADD: begin
                if (r_count >= DEPTH_CNT) begin
                    n_event = cadc_pkg::EV_TBL_FULL;
                end else if (r_found) begin
                    n_event = cadc_pkg::EV_DUPLICATE;
                end else begin
                    n_event   = cadc_pkg::EV_ADDED;
                    do_append = 1'b1;
                end
            end
            default: n_event = cadc_pkg::EV_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= cadc_pkg::MODE_IDLE;
            r_hold  <= '0;
            r_count <= RESET_CNT;
            for (int i = 0; i < cadc_pkg::TABLE_DEPTH; i++) begin
                r_table[i] <= (i < cadc_pkg::PRESET_N) ? cadc_pkg::preset_uid(i) : '0;
            end
        end else if (i_cmd.apply) begin
            r_mode <= n_mode;
            r_hold <= n_hold;
            if (do_append) begin
                r_table[r_count[cadc_pkg::IDX_W-1:0]] <= r_uid;
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.apply) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_res_event <= n_event;
            r_res_a     <= r_a_busy;
            r_res_b     <= r_b_busy;
        end
    end

    // Mode and count change only on a commit, so they stand in the output word.
    assign count_ext        = {5'd0, r_count};
    assign o_out_valid      = r_out_valid;
    assign o_event_code     = r_res_event;
    assign o_door_mode      = r_mode;
    assign o_door_open      = (r_mode == cadc_pkg::MODE_OPEN);
    assign o_slot_a_busy    = r_res_a;
    assign o_slot_b_busy    = r_res_b;
    assign o_occupied_count = {1'b0, r_res_a} + {1'b0, r_res_b};
    assign o_stored_cards   = count_ext[4:0];

endmodule

/* hdl/card_access_door_controller.sv */
// ----------------------------------------------------------------------------
// card_access_door_controller: parking barrier with a card allow list
// Top level joining the sequencing state machine and the datapath.
// ----------------------------------------------------------------------------
// One word is in work at a time. A tick or an ignored scan is committed
// with no list search; a scan or add that walks the allow list compares
// the entries one after another through the single compare port on the
// list. The result sits in an output register, and the next word is
// accepted as soon as the current one has been committed to it, even if
// the result is not yet taken.
module card_access_door_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [39:0] i_card_uid,
    input  logic [9:0]  i_slot_a_distance,
    input  logic [9:0]  i_slot_b_distance,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_code,
    output logic [1:0]  o_door_mode,
    output logic        o_door_open,
    output logic        o_slot_a_busy,
    output logic        o_slot_b_busy,
    output logic [1:0]  o_occupied_count,
    output logic [4:0]  o_stored_cards
);

    cadc_pkg::t_cmd cmd;
    cadc_pkg::t_sts sts;

    cadc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cadc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_op              (i_op),
        .i_card_uid        (i_card_uid),
        .i_slot_a_distance (i_slot_a_distance),
        .i_slot_b_distance (i_slot_b_distance),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_event_code      (o_event_code),
        .o_door_mode       (o_door_mode),
        .o_door_open       (o_door_open),
        .o_slot_a_busy     (o_slot_a_busy),
        .o_slot_b_busy     (o_slot_b_busy),
        .o_occupied_count  (o_occupied_count),
        .o_stored_cards    (o_stored_cards)
    );

endmodule

/* hdl/cadc_checker.sv */
// ----------------------------------------------------------------------------
// cadc_sva: port-level checks for the door controller
// Watches the top level ports and flags inconsistent result words.
// ----------------------------------------------------------------------------
module cadc_sva (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_event_code,
    input logic [1:0] o_door_mode,
    input logic       o_door_open,
    input logic       o_slot_a_busy,
    input logic       o_slot_b_busy,
    input logic [1:0] o_occupied_count
);

    a_door_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_door_open == (o_door_mode == cadc_pkg::MODE_OPEN)))
        else $error("door_open disagrees with door_mode");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_occupied_count == ({1'b0, o_slot_a_busy} + {1'b0, o_slot_b_busy})))
        else $error("occupied_count disagrees with slot lamps");

    // A denial can never leave the barrier open, and a grant never locks it.
    a_event_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_event_code == cadc_pkg::EV_DENY_UNK) ||
                         (o_event_code == cadc_pkg::EV_DENY_FULL)))
            |-> (o_door_mode != cadc_pkg::MODE_OPEN)
        ) else $error("denied scan with door open");

    a_grant_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_code == cadc_pkg::EV_GRANTED))
            |-> (o_door_mode != cadc_pkg::MODE_LOCK))
        else $error("granted scan with door locked");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_event_code)))
        else $error("stalled result word changed");

endmodule

bind card_access_door_controller cadc_sva u_cadc_sva (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_event_code     (o_event_code),
    .o_door_mode      (o_door_mode),
    .o_door_open      (o_door_open),
    .o_slot_a_busy    (o_slot_a_busy),
    .o_slot_b_busy    (o_slot_b_busy),
    .o_occupied_count (o_occupied_count)
);

/* verif/cadc_checker.sv */
// ----------------------------------------------------------------------------
// cadc_checker: result predictor and scoreboard for the door controller
// Watches the register port and both word channels. Each accepted input word
// is run through a local model of the gate, and each result word leaving the
// block is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cadc_checker
    import cadc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_op,
    input  logic [39:0] i_card_uid,
    input  logic [9:0]  i_slot_a_distance,
    input  logic [9:0]  i_slot_b_distance,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_event_code,
    input  logic [1:0]  i_door_mode,
    input  logic        i_door_open,
    input  logic        i_slot_a_busy,
    input  logic        i_slot_b_busy,
    input  logic [1:0]  i_occupied_count,
    input  logic [4:0]  i_stored_cards,
    output int          o_mismatches,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] event_code;
        logic [1:0] door_mode;
        logic       door_open;
        logic       a_busy;
        logic       b_busy;
        logic [1:0] occupied;
        logic [4:0] stored;
    } t_gate_status;

    localparam logic [PRESET_N-1:0][UID_W-1:0] FACTORY_CARDS = {
        40'hA473C44152, 40'h4027C441E2, 40'hF094D85CE0, 40'h56622E0218
    };

    // Local copy of the gate state and its settings.
    logic [DIST_W-1:0] near_thr;
    logic [HOLD_W-1:0] open_hold;
    logic [HOLD_W-1:0] deny_hold;
    logic [1:0]        capacity;
    logic [1:0]        gate_mode;
    logic [HOLD_W-1:0] hold_count;
    logic [UID_W-1:0]  allow_list [TABLE_DEPTH];
    int unsigned       card_count;

    t_gate_status      expected_status [$];

    function automatic logic is_near(input logic [DIST_W-1:0] distance);
        return (distance != '0) && (distance <= near_thr);
    endfunction

    function automatic logic card_allowed(input logic [UID_W-1:0] uid);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i < card_count && allow_list[i] == uid) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [HOLD_W-1:0] active_hold();
        return (gate_mode == MODE_OPEN) ? open_hold : deny_hold;
    endfunction

    task automatic predict_gate_word(input logic [1:0] op, input logic [UID_W-1:0] uid,
                                     input logic [DIST_W-1:0] dist_a,
                                     input logic [DIST_W-1:0] dist_b);
        t_gate_status st;
        logic [1:0]   occ;
        st.a_busy     = is_near(dist_a);
        st.b_busy     = is_near(dist_b);
        occ           = {1'b0, st.a_busy} + {1'b0, st.b_busy};
        st.event_code = EV_NONE;
        case (op)
            OP_TICK: begin
                if (gate_mode != MODE_IDLE) begin
                    if (hold_count != '1) begin
                        hold_count = hold_count + 1'b1;
                    end
                    if (hold_count >= active_hold()) begin
                        gate_mode = MODE_IDLE;
                    end
                end
            end
            OP_SCAN: begin
                // Scans are only served with the barrier at rest.
                if (gate_mode == MODE_IDLE) begin
                    if (occ >= capacity) begin
                        st.event_code = EV_DENY_FULL;
                        gate_mode     = MODE_LOCK;
                    end else if (card_allowed(uid)) begin
                        st.event_code = EV_GRANTED;
                        gate_mode     = MODE_OPEN;
                    end else begin
                        st.event_code = EV_DENY_UNK;
                        gate_mode     = MODE_LOCK;
                    end
                    hold_count = '0;
                    if (active_hold() == '0) begin
                        gate_mode = MODE_IDLE;
                    end
                end
            end
            OP_ADD: begin
                // A full table answers before the duplicate search.
                if (card_count >= TABLE_DEPTH) begin
                    st.event_code = EV_TBL_FULL;
                end else if (card_allowed(uid)) begin
                    st.event_code = EV_DUPLICATE;
                end else begin
                    allow_list[card_count] = uid;
                    card_count             = card_count + 1;
                    st.event_code          = EV_ADDED;
                end
            end
            default: begin
            end
        endcase
        st.door_mode = gate_mode;
        st.door_open = (gate_mode == MODE_OPEN);
        st.occupied  = occ;
        st.stored    = card_count[4:0];
        expected_status.push_back(st);
    endtask

    always @(posedge i_clk) begin
        t_gate_status got;
        t_gate_status want;
        if (!i_rst_n) begin
            near_thr   = RST_NEAR_THR;
            open_hold  = RST_OPEN_HOLD;
            deny_hold  = RST_DENY_HOLD;
            capacity   = RST_CAPACITY;
            gate_mode  = MODE_IDLE;
            hold_count = '0;
            card_count = RESET_CNT;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                allow_list[i] = (i < RESET_CNT) ? FACTORY_CARDS[i] : '0;
            end
            expected_status.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_NEAR_THR:  near_thr  = i_cfg_wdata[DIST_W-1:0];
                    REG_OPEN_HOLD: open_hold = i_cfg_wdata;
                    REG_DENY_HOLD: deny_hold = i_cfg_wdata;
                    REG_CAPACITY:  capacity  = i_cfg_wdata[1:0];
                    default: begin
                    end
                endcase
            end
            // A result can never leave on the edge its own word enters, so
            // the compare goes ahead of the prediction.
            if (i_out_valid && !i_out_stall) begin
                got = {i_event_code, i_door_mode, i_door_open, i_slot_a_busy,
                       i_slot_b_busy, i_occupied_count, i_stored_cards};
                if (expected_status.size() == 0) begin
                    o_mismatches = o_mismatches + 1;
                    if (o_mismatches <= 10) begin
                        $display("%0t: unexpected result word ev=%0d mode=%0d open=%0d",
                                 $realtime, got.event_code, got.door_mode, got.door_open);
                    end
                end else begin
                    want = expected_status.pop_front();
                    if (got != want) begin
                        o_mismatches = o_mismatches + 1;
                        if (o_mismatches <= 10) begin
                            $display("%0t: result mismatch (event/mode/open/a/b/occ/cards)",
                                     $realtime);
                            $display("    expected %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                                     want.event_code, want.door_mode, want.door_open,
                                     want.a_busy, want.b_busy, want.occupied, want.stored);
                            $display("    actual   %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                                     got.event_code, got.door_mode, got.door_open,
                                     got.a_busy, got.b_busy, got.occupied, got.stored);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_gate_word(i_op, i_card_uid, i_slot_a_distance, i_slot_b_distance);
            end
        end
        o_pending = expected_status.size();
    end

endmodule

/* verif/tb_card_access_door_controller.sv */
// ----------------------------------------------------------------------------
// tb_card_access_door_controller: stimulus and verdict for the door controller
// Drives a directed opening sequence and then randomized phases of ticks,
// scans and card adds under changing settings, with random gaps and output
// stalls. Results are checked by the scoreboard beside the block and by the bound port checks.
// ----------------------------------------------------------------------------
module tb_card_access_door_controller;
    import cadc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NOP     = 2'd3;
    localparam int         CYCLE_CAP  = 500_000;
    localparam int         PHASES     = 10;
    localparam int         PHASE_WORDS = 105;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = OP_TICK;
    logic [39:0] card_uid = '0;
    logic [9:0]  dist_a = '0;
    logic [9:0]  dist_b = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  event_code;
    logic [1:0]  door_mode;
    logic        door_open;
    logic        slot_a_busy;
    logic        slot_b_busy;
    logic [1:0]  occupied_count;
    logic [4:0]  stored_cards;

    int          mismatches;
    int          pending;
    int          cycles = 0;
    int          stall_left = 0;
    logic        quiet = 1'b0;
    logic [9:0]  cur_thr = RST_NEAR_THR;
    logic [39:0] known_cards [$];

    always #5 i_clk = ~i_clk;

    card_access_door_controller dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_addr       (cfg_addr),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_op             (op),
        .i_card_uid       (card_uid),
        .i_slot_a_distance(dist_a),
        .i_slot_b_distance(dist_b),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_event_code     (event_code),
        .o_door_mode      (door_mode),
        .o_door_open      (door_open),
        .o_slot_a_busy    (slot_a_busy),
        .o_slot_b_busy    (slot_b_busy),
        .o_occupied_count (occupied_count),
        .o_stored_cards   (stored_cards)
    );

    cadc_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_addr       (cfg_addr),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_op             (op),
        .i_card_uid       (card_uid),
        .i_slot_a_distance(dist_a),
        .i_slot_b_distance(dist_b),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_event_code     (event_code),
        .i_door_mode      (door_mode),
        .i_door_open      (door_open),
        .i_slot_a_busy    (slot_a_busy),
        .i_slot_b_busy    (slot_b_busy),
        .i_occupied_count (occupied_count),
        .i_stored_cards   (stored_cards),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly short waits, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Result side back-pressure.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (i_rst_n && !quiet && $urandom_range(0, 99) < 25) begin
            stall_left <= idle_gap();
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [1:0] w_op, input logic [39:0] w_uid,
                             input logic [9:0] w_a, input logic [9:0] w_b);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        op       = w_op;
        card_uid = w_uid;
        dist_a   = w_a;
        dist_b   = w_b;
        in_valid = 1'b1;
        do begin
            @(posedge i_clk);
        end while (in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [15:0] data);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(negedge i_clk);
        cfg_we    = 1'b0;
        if (addr == REG_NEAR_THR) begin
            cur_thr = data[9:0];
        end
    endtask

    function automatic logic [39:0] random_uid();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[39:0];
    endfunction

    // Distances cluster around the current threshold.
    function automatic logic [9:0] pick_distance();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return '0;
        end
        if (r < 45 && cur_thr != 0) begin
            return 10'($urandom_range(1, cur_thr));
        end
        if (r < 60 && cur_thr != 10'h3FF) begin
            return cur_thr + 1'b1;
        end
        if (r < 70) begin
            return 10'h3FF;
        end
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic logic [15:0] pick_hold();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end
        if (r < 14) begin
            return 16'hFFFF;
        end
        if (r < 18) begin
            return 16'($urandom_range(100, 65534));
        end
        return 16'($urandom_range(1, 12));
    endfunction

    task automatic random_word();
        int          r;
        logic [39:0] uid;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 60) begin
            uid = known_cards[$urandom_range(0, known_cards.size() - 1)];
        end else begin
            uid = random_uid();
        end
        if (r < 4) begin
            send_word(OP_NOP, random_uid(), pick_distance(), pick_distance());
        end else if (r < 46) begin
            send_word(OP_TICK, random_uid(), pick_distance(), pick_distance());
        end else if (r < 88) begin
            send_word(OP_SCAN, uid, pick_distance(), pick_distance());
        end else begin
            if ($urandom_range(0, 1) == 0) begin
                uid = random_uid();
                known_cards.push_back(uid);
            end
            send_word(OP_ADD, uid, pick_distance(), pick_distance());
        end
    endtask

    initial begin
        for (int i = 0; i < RESET_CNT; i++) begin
            known_cards.push_back(preset_uid(i));
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Settings as they come out of reset.
        send_word(OP_SCAN, preset_uid(0), 10'd0, 10'd0);
        send_word(OP_SCAN, 40'h0000000001, 10'd3, 10'd9);
        send_word(OP_TICK, '0, 10'd5, 10'd6);
        send_word(OP_ADD, preset_uid(1), 10'd0, 10'd1);
        send_word(OP_ADD, 40'hFFFFFFFFFF, 10'h3FF, 10'd0);
        known_cards.push_back(40'hFFFFFFFFFF);
        send_word(OP_NOP, 40'hFFFFFFFFFF, 10'd1, 10'd5);

        // Short open hold releases the door; zero lockout hold.
        drain_results();
        write_reg(REG_OPEN_HOLD, 16'd1);
        write_reg(REG_DENY_HOLD, 16'd0);
        write_reg(REG_NEAR_THR, 16'd1023);
        send_word(OP_TICK, '0, 10'd0, 10'd0);
        send_word(OP_TICK, 40'h5555555555, 10'd0, 10'd0);
        send_word(OP_SCAN, 40'hFFFFFFFFFF, 10'h3FF, 10'h3FF);
        send_word(OP_SCAN, '0, 10'd1, 10'd0);
        send_word(OP_SCAN, 40'hFFFFFFFFFF, 10'd0, 10'd0);
        send_word(OP_TICK, 40'hAAAAAAAAAA, 10'd512, 10'd0);

        // Zero capacity: every scan is a full denial.
        drain_results();
        write_reg(REG_NEAR_THR, 16'd0);
        write_reg(REG_CAPACITY, 16'd0);
        write_reg(REG_DENY_HOLD, 16'd2);
        send_word(OP_SCAN, preset_uid(3), 10'h3FF, 10'd5);
        send_word(OP_TICK, '0, 10'd0, 10'd0);
        send_word(OP_TICK, '0, 10'd0, 10'd0);

        // Capacity three never counts as full.
        drain_results();
        write_reg(REG_CAPACITY, 16'd3);
        write_reg(REG_NEAR_THR, 16'd5);
        send_word(OP_SCAN, preset_uid(2), 10'd5, 10'd5);
        send_word(OP_TICK, '0, 10'd6, 10'd4);
        send_word(OP_SCAN, '0, 10'd6, 10'd5);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            quiet = (ph % 4 == 3);
            case (ph)
                0: begin
                    write_reg(REG_NEAR_THR, 16'd1023);
                    write_reg(REG_OPEN_HOLD, 16'hFFFF);
                    write_reg(REG_DENY_HOLD, 16'd0);
                    write_reg(REG_CAPACITY, 16'd3);
                end
                1: begin
                    write_reg(REG_NEAR_THR, 16'd0);
                    write_reg(REG_OPEN_HOLD, 16'd0);
                    write_reg(REG_DENY_HOLD, 16'hFFFF);
                    write_reg(REG_CAPACITY, 16'd0);
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0:       write_reg(REG_NEAR_THR, 16'd0);
                        1:       write_reg(REG_NEAR_THR, 16'd1023);
                        2:       write_reg(REG_NEAR_THR, 16'd5);
                        default: write_reg(REG_NEAR_THR, 16'($urandom_range(1, 64)));
                    endcase
                    write_reg(REG_OPEN_HOLD, pick_hold());
                    write_reg(REG_DENY_HOLD, pick_hold());
                    write_reg(REG_CAPACITY, 16'($urandom_range(0, 3)));
                end
            endcase
            repeat (PHASE_WORDS) random_word();
        end

        drain_results();
        quiet = 1'b0;
        repeat (40) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
